// ===== src/cdq_pkg.sv =====
// Shared types and constants for the circular double-ended queue.
`default_nettype none

package cdq_pkg;

    localparam int WORD_W      = 32;
    localparam int ACTION_W    = 3;
    localparam int SLOTS_W     = 5;
    localparam int S_TDATA_W   = 40;
    localparam int M_PAYLOAD_W = 99;
    localparam int M_TDATA_W   = 104;

    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;
    localparam logic [WORD_W-1:0]  NONE_WORD   = 32'hFFFF_FFFF;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PEEK       = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_LOAD
    } cdq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_out;
    } cdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } cdq_status_t;

endpackage

`default_nettype wire

// ===== src/cdq_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire cdq_status_t status,
    output cdq_cmd_t         cmd
);

    cdq_state_t state_reg;
    cdq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_FETCH;
            end
            // The store is read at the updated indices during this cycle.
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/cdq_datapath.sv =====
// Datapath: slot store, head and tail indices, capacity register and result register.
`default_nettype none

module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int MAX_SLOTS = 16
)
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [SLOTS_W-1:0]      cfg_wdata,
    input  wire logic [S_TDATA_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_TDATA_W-1:0]         m_tdata,
    input  wire cdq_cmd_t                cmd,
    output cdq_status_t                  status
);

    localparam int AW   = $clog2(MAX_SLOTS);
    localparam int CMPW = (AW + 1 > SLOTS_W) ? AW + 1 : SLOTS_W;
    localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_SLOTS);

    logic [WORD_W-1:0] store_mem [MAX_SLOTS];

    logic [SLOTS_W-1:0]     slots_reg;
    logic [AW-1:0]          head_reg, head_next;
    logic [AW-1:0]          tail_reg, tail_next;
    logic                   empty_reg, empty_next;
    logic [ACTION_W-1:0]    action_reg;
    logic [WORD_W-1:0]      value_reg;
    logic                   accepted_reg, accepted_next;
    logic [WORD_W-1:0]      popped_reg, popped_next;
    logic [WORD_W-1:0]      rd_head_reg;
    logic [WORD_W-1:0]      rd_tail_reg;
    logic [M_PAYLOAD_W-1:0] out_reg;
    logic                   out_valid_reg;

    logic [CMPW-1:0] slots_ext;
    logic [AW-1:0]   last_idx;
    logic [AW-1:0]   head_inc, head_dec, tail_inc, tail_dec;
    logic            full;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;

    // Highest index in use: the capacity clamped to one through MAX_SLOTS, minus one.
    assign slots_ext = CMPW'(slots_reg);
    always_comb begin
        if (slots_ext == '0) begin
            last_idx = '0;
        end else if (slots_ext > MAX_C) begin
            last_idx = AW'(MAX_C - CMPW'(1));
        end else begin
            last_idx = AW'(slots_ext - CMPW'(1));
        end
    end

    assign head_inc = (head_reg == last_idx) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? last_idx : head_reg - AW'(1);
    assign tail_inc = (tail_reg == last_idx) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? last_idx : tail_reg - AW'(1);
    assign full     = !empty_reg && (tail_inc == head_reg);

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        accepted_next = 1'b0;
        popped_next   = NONE_WORD;
        wr_en         = 1'b0;
        wr_addr       = '0;
        case (action_reg) inside
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (!full) begin
                    accepted_next = 1'b1;
                    wr_en         = 1'b1;
                    if (empty_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        wr_addr    = '0;
                    end else if (action_reg == ACT_PUSH_FRONT) begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end else begin
                        tail_next = tail_inc;
                        wr_addr   = tail_inc;
                    end
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
                if (!empty_reg) begin
                    accepted_next = 1'b1;
                    popped_next   = (action_reg == ACT_POP_FRONT) ? rd_head_reg : rd_tail_reg;
                    if (head_reg == tail_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end else if (action_reg == ACT_POP_FRONT) begin
                        head_next = head_inc;
                    end else begin
                        tail_next = tail_dec;
                    end
                end
            end
            ACT_PEEK: begin
                accepted_next = 1'b1;
            end
            default: begin
                accepted_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= SLOTS_RESET;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (cfg_we) begin
            slots_reg <= cfg_wdata;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg <= s_tdata[ACTION_W-1:0];
            value_reg  <= s_tdata[ACTION_W +: WORD_W];
        end
        if (cmd.exec) begin
            accepted_reg <= accepted_next;
            popped_reg   <= popped_next;
        end
    end

    // The store is read every cycle at the current indices.
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            store_mem[wr_addr] <= value_reg;
        end
        rd_head_reg <= store_mem[head_reg];
        rd_tail_reg <= store_mem[tail_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {empty_reg ? NONE_WORD : rd_tail_reg,
                        empty_reg ? NONE_WORD : rd_head_reg,
                        full, empty_reg, popped_reg, accepted_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {(M_TDATA_W - M_PAYLOAD_W)'(0), out_reg};

endmodule

`default_nettype wire

// ===== src/circular_double_ended_queue.sv =====
// Top level of the circular double-ended queue.
`default_nettype none

// A deque of signed 32-bit words in a circular store of MAX_SLOTS entries, of
// which cfg_wdata (clamped to one through MAX_SLOTS) are used; any capacity write
// empties the deque. Each request is one action (push front, push rear, pop front,
// pop rear, peek) and yields one result with the acceptance flag, the popped word,
// the empty and full flags and the front and rear words. A request goes from
// acceptance to a loaded result in these steps, in order: accept it, update the
// indices and write the store, read the store at the new indices through its
// registered read ports, and load the result register. The load step repeats
// while the result register still holds an earlier result that has not been
// taken. The next request is accepted right after the load, even while that
// result still waits.
module circular_double_ended_queue
    import cdq_pkg::*;
#(
    parameter int MAX_SLOTS = 16
)
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [SLOTS_W-1:0]   cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // action [2:0], push_value [34:3], zeros above
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // accepted [0], popped_value [32:1], is_empty [33], is_full [34],
    // front_word [66:35], rear_word [98:67], zeros above
    output logic [M_TDATA_W-1:0]      m_tdata
);

    cdq_cmd_t    cmd;
    cdq_status_t status;

    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cdq_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
